// ----- design/fsb_pkg.sv -----
// shared types, constants and helper functions for the free space bitmap
package fsb_pkg;

  localparam int MAX_BYTES_DEF = 128;
  localparam int BIT_IDX_W     = 10;
  localparam int BYTE_IDX_W    = 7;
  localparam int DATA_W        = 8;
  localparam int CFG_W         = 8;
  localparam int CFG_RESET     = 128;
  localparam int SCAN_LANES    = 16;
  localparam int LANE_W        = 4;

  localparam logic [2:0] OP_MARK      = 3'd0;
  localparam logic [2:0] OP_CLEAR     = 3'd1;
  localparam logic [2:0] OP_TEST      = 3'd2;
  localparam logic [2:0] OP_WRITE     = 3'd3;
  localparam logic [2:0] OP_READ      = 3'd4;
  localparam logic [2:0] OP_CLEAR_ALL = 3'd5;

  typedef struct packed {
    logic [2:0]            operation;
    logic [BIT_IDX_W-1:0]  bit_index;
    logic [BYTE_IDX_W-1:0] byte_index;
    logic [DATA_W-1:0]     byte_data;
  } fsb_in_t;

  typedef struct packed {
    logic                 bit_value;
    logic [DATA_W-1:0]    read_data;
    logic                 is_empty;
    logic                 found;
    logic [BIT_IDX_W-1:0] first_index;
    logic                 out_of_range;
  } fsb_out_t;

  // update of the per-byte nonzero summary
  typedef struct packed {
    logic we;
    logic clr_all;
    logic nz;
  } fsb_upd_t;

  // outcome of one scan step over a group of summary bits
  typedef struct packed {
    logic              hit;
    logic [LANE_W-1:0] lane;
  } fsb_hit_t;

  // position of the first set bit, msb first
  function automatic logic [2:0] first_set8(input logic [7:0] v);
    logic [2:0] k;
    k = 3'd7;
    for (int i = 0; i < 8; i++) begin
      if (v[i]) k = 3'(7 - i);
    end
    return k;
  endfunction

  // lowest set lane of a scan group
  function automatic logic [LANE_W-1:0] first_lane(input logic [SCAN_LANES-1:0] v);
    logic [LANE_W-1:0] k;
    k = '0;
    for (int i = SCAN_LANES - 1; i >= 0; i--) begin
      if (v[i]) k = LANE_W'(i);
    end
    return k;
  endfunction

endpackage

// ----- design/fsb_ram.sv -----
// generic single write port, single read port ram with registered read
module fsb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- design/fsb_sum.sv -----
// per-byte nonzero summary bits and the grouped first-nonzero scan
module fsb_sum
  import fsb_pkg::*;
#(
  parameter int MAX_BYTES = MAX_BYTES_DEF,
  localparam int AW  = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1,
  localparam int UW  = $clog2(MAX_BYTES + 1),
  localparam int CW  = (UW > CFG_W) ? UW : CFG_W,
  localparam int NCH = (MAX_BYTES + SCAN_LANES - 1) / SCAN_LANES,
  localparam int CNW = (NCH > 1) ? $clog2(NCH) : 1
) (
  input  logic           clk,
  input  logic           rst_n,
  input  fsb_upd_t       upd,
  input  logic [AW-1:0]  upd_addr,
  input  logic [AW-1:0]  look_addr,
  output logic           look_nz,
  input  logic [CNW-1:0] scan_cnt,
  input  logic [CW-1:0]  used,
  output fsb_hit_t       scan_hit
);

  localparam int SW = CNW + LANE_W;
  localparam int KW = (SW > CW) ? SW : CW;
  localparam int PW = NCH * SCAN_LANES;

  logic [MAX_BYTES-1:0]  nz_r;
  logic [PW-1:0]         nz_pad;
  logic [SCAN_LANES-1:0] grp;
  logic [SCAN_LANES-1:0] grp_used;

  always_ff @(posedge clk) begin
    if (!rst_n || upd.clr_all) begin
      nz_r <= '0;
    end else if (upd.we) begin
      nz_r[upd_addr] <= upd.nz;
    end
  end

  always_comb begin
    nz_pad = '0;
    nz_pad[MAX_BYTES-1:0] = nz_r;
  end

  assign look_nz = nz_pad[look_addr];
  assign grp     = nz_pad[scan_cnt*SCAN_LANES +: SCAN_LANES];

  // only bytes below the used size take part in the search
  always_comb begin
    for (int i = 0; i < SCAN_LANES; i++) begin
      grp_used[i] = grp[i] && (KW'({scan_cnt, LANE_W'(i)}) < KW'(used));
    end
  end

  assign scan_hit.hit  = |grp_used;
  assign scan_hit.lane = first_lane(grp_used);

endmodule

// ----- design/free_space_bitmap.sv -----
// free space bitmap: top level with operation sequencer and result register
//
// Bit store of MAX_BYTES bytes, bits numbered msb first within each byte.
// Input channel in_valid/in_ready/in_data carries one operation per beat:
// mark, clear or test a bit, write or read a byte, or clear all. The result
// channel out_valid/out_ready/out_data returns one beat per input beat, in
// order, holding the operation's outcome plus the empty flag and the index
// of the first marked bit within the used bytes, taken after the operation.
// cfg_we/cfg_wdata sets the number of bytes in use (saturates at MAX_BYTES);
// write it only while the block is idle.
// An accepted item passes the read-modify-write step, then scans the nonzero
// summary bits 16 bytes per cycle, then fetches the first nonzero byte when
// one is found, and then loads the result register.
// The next item is taken as soon as the previous result is loaded, even if
// that result still waits for out_ready; a stalled receiver holds the
// result and then blocks only the load of the following one.
// Reset clears the summary bits, so the whole store reads as zero at once,
// and sets bytes in use to 128.
module free_space_bitmap
  import fsb_pkg::*;
#(
  parameter int MAX_BYTES = MAX_BYTES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  fsb_in_t          in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output fsb_out_t         out_data,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata
);

  localparam int AW  = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
  localparam int UW  = $clog2(MAX_BYTES + 1);
  localparam int CW  = (UW > CFG_W) ? UW : CFG_W;
  localparam int NCH = (MAX_BYTES + SCAN_LANES - 1) / SCAN_LANES;
  localparam int CNW = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int SW  = CNW + LANE_W;
  localparam int IW  = (AW > BYTE_IDX_W) ? AW : BYTE_IDX_W;
  localparam int FX  = (SW > BYTE_IDX_W) ? SW : BYTE_IDX_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RMW,
    S_SCAN,
    S_FETCH,
    S_OUT
  } state_t;

  state_t                state_r;
  fsb_in_t               item_r;
  logic [AW-1:0]         addr_r;
  logic                  oor_r;
  logic [CNW-1:0]        cnt_r;
  logic                  bitv_r;
  logic [DATA_W-1:0]     rd_r;
  logic                  found_r;
  logic [BIT_IDX_W-1:0]  first_r;
  logic [BYTE_IDX_W-1:0] fbyte_r;
  logic                  out_valid_r;
  fsb_out_t              out_r;
  logic [CFG_W-1:0]      cfg_r;

  logic [CW-1:0]         used;
  logic                  in_bit_op;
  logic                  in_byte_op;
  logic [BYTE_IDX_W-1:0] in_byte;
  logic [IW-1:0]         in_byte_w;
  logic                  in_oor;
  logic                  accept;

  logic                  look_nz;
  logic [DATA_W-1:0]     ram_rdata;
  logic [DATA_W-1:0]     cur;
  logic [DATA_W-1:0]     mask;
  logic [DATA_W-1:0]     wdata;
  fsb_upd_t              upd;
  logic                  bitv_nxt;
  logic [DATA_W-1:0]     rd_nxt;
  fsb_hit_t              hit;
  logic [SW-1:0]         scan_addr;
  logic [FX-1:0]         scan_addr_x;
  logic                  ram_re;
  logic [AW-1:0]         ram_raddr;
  logic                  out_load;

  // used size saturates at the store depth
  assign used = (CW'(cfg_r) > CW'(MAX_BYTES)) ? CW'(MAX_BYTES) : CW'(cfg_r);

  assign in_bit_op  = (in_data.operation == OP_MARK) || (in_data.operation == OP_CLEAR) ||
                      (in_data.operation == OP_TEST);
  assign in_byte_op = (in_data.operation == OP_WRITE) || (in_data.operation == OP_READ);
  assign in_byte    = in_bit_op ? in_data.bit_index[BIT_IDX_W-1:3] : in_data.byte_index;
  assign in_byte_w  = IW'(in_byte);
  assign in_oor     = (in_bit_op || in_byte_op) && !(CW'(in_byte) < used);

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  // bytes without a summary bit hold stale data and read as zero
  assign cur  = look_nz ? ram_rdata : '0;
  assign mask = 8'h80 >> item_r.bit_index[2:0];

  always_comb begin
    upd      = '0;
    wdata    = '0;
    bitv_nxt = 1'b0;
    rd_nxt   = '0;
    if (state_r == S_RMW) begin
      unique case (item_r.operation)
        OP_MARK: begin
          wdata  = cur | mask;
          upd.we = !oor_r;
        end
        OP_CLEAR: begin
          wdata  = cur & ~mask;
          upd.we = !oor_r;
        end
        OP_TEST: begin
          bitv_nxt = !oor_r && ((cur & mask) != '0);
        end
        OP_WRITE: begin
          wdata  = item_r.byte_data;
          upd.we = !oor_r;
        end
        OP_READ: begin
          rd_nxt = oor_r ? '0 : cur;
        end
        OP_CLEAR_ALL: begin
          upd.clr_all = 1'b1;
        end
        default: begin
        end
      endcase
    end
    upd.nz = (wdata != '0);
  end

  assign scan_addr   = {cnt_r, hit.lane};
  assign scan_addr_x = FX'(scan_addr);
  assign ram_re      = accept || ((state_r == S_SCAN) && hit.hit);
  assign ram_raddr   = (state_r == S_SCAN) ? scan_addr_x[AW-1:0] : in_byte_w[AW-1:0];
  assign out_load    = (state_r == S_OUT) && (!out_valid_r || out_ready);

  fsb_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAX_BYTES)
  ) u_ram (
    .clk   (clk),
    .we    (upd.we),
    .waddr (addr_r),
    .wdata (wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  fsb_sum #(
    .MAX_BYTES (MAX_BYTES)
  ) u_sum (
    .clk       (clk),
    .rst_n     (rst_n),
    .upd       (upd),
    .upd_addr  (addr_r),
    .look_addr (addr_r),
    .look_nz   (look_nz),
    .scan_cnt  (cnt_r),
    .used      (used),
    .scan_hit  (hit)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_W'(CFG_RESET);
    end else if (cfg_we) begin
      cfg_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            item_r  <= in_data;
            addr_r  <= in_byte_w[AW-1:0];
            oor_r   <= in_oor;
            state_r <= S_RMW;
          end
        end
        S_RMW: begin
          bitv_r  <= bitv_nxt;
          rd_r    <= rd_nxt;
          cnt_r   <= '0;
          state_r <= S_SCAN;
        end
        S_SCAN: begin
          if (hit.hit) begin
            fbyte_r <= scan_addr_x[BYTE_IDX_W-1:0];
            state_r <= S_FETCH;
          end else if (cnt_r == CNW'(NCH - 1)) begin
            found_r <= 1'b0;
            first_r <= '0;
            state_r <= S_OUT;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_FETCH: begin
          found_r <= 1'b1;
          first_r <= {fbyte_r, first_set8(ram_rdata)};
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r || out_ready) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload register, loaded only when the previous beat is gone
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r.bit_value    <= bitv_r;
      out_r.read_data    <= rd_r;
      out_r.is_empty     <= !found_r;
      out_r.found        <= found_r;
      out_r.first_index  <= first_r;
      out_r.out_of_range <= oor_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_empty_vs_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.is_empty != out_data.found))
    else $error("is_empty and found disagree");

  a_oor_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.out_of_range) |->
      (!out_data.bit_value && (out_data.read_data == '0)))
    else $error("ignored operation returned data");

  a_none_zero_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.found) |-> (out_data.first_index == '0))
    else $error("first index set with nothing found");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second item taken while one is in flight");

endmodule
